### src/prld_pkg.sv
// ----------------------------------------------------------------------------
// prld_pkg: shared types and constants of the packed run-length decoder
// Item structs, parser phases, register indexes and the front-to-back command.
// ----------------------------------------------------------------------------
`default_nettype none
package prld_pkg;

  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] row_bits;
    logic [5:0]  row_index;
    logic        last_row;
    logic        error_flag;
  } out_item_t;

  localparam logic [1:0] REG_RUN_PARAM    = 2'd0;
  localparam logic [1:0] REG_FIRST_BLACK  = 2'd1;
  localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd2;
  localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_MEDIUM = 2'd1,
    PH_ZEROS  = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  // Command from the front to the back.
  typedef enum logic [2:0] {
    CMD_RUN    = 3'd0,  // paint a run of value pixels
    CMD_REPEAT = 3'd1,  // set the row repeat count to value
    CMD_RAW    = 3'd2,  // paint eight raw bits
    CMD_END    = 3'd3,  // end of glyph: flush or error, then clear
    CMD_NOP    = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] value;
    logic        black;
  } cmd_t;

endpackage
`default_nettype wire

### src/prld_front.sv
// ----------------------------------------------------------------------------
// prld_front: byte intake and packed-number parser
// Splits bytes into nybbles for run and repeat commands or passes them raw.
// ----------------------------------------------------------------------------
`default_nettype none
module prld_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [3:0]        run_param,
  input  wire logic              first_black,
  input  wire prld_pkg::in_item_t in_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output prld_pkg::cmd_t         cmd,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready
);

  // Step 0 handles the high nybble, step 1 the low one, step 2 the end marker.
  logic [1:0]         step_r, step_nxt;
  logic               busy_r, busy_nxt;
  prld_pkg::in_item_t item_r, item_nxt;
  prld_pkg::phase_t   phase_r, phase_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [3:0]         zc_r, zc_nxt;
  logic               rep_r, rep_nxt;
  logic               colour_r, colour_nxt;

  logic        raw;
  logic [3:0]  d;
  logic [31:0] acc_shift;
  logic [35:0] long_v;
  logic [31:0] med_v;
  logic        num_done;
  logic [31:0] num_val;

  assign raw = run_param[3] & run_param[2] & run_param[1];
  assign d   = (step_r == 2'd0) ? item_r.data_byte[7:4] : item_r.data_byte[3:0];
  assign in_ready = !busy_r;
  assign acc_shift = (acc_r > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF : {acc_r[27:0], d};
  assign med_v = ({28'd0, acc_r[3:0]} - {28'd0, run_param} - 32'd1) * 32'd16
                 + {28'd0, d} + {28'd0, run_param} + 32'd1;
  assign long_v = {4'd0, acc_shift} - 36'd15
                  + {24'd0, (8'd13 - {4'd0, run_param}), 4'd0} + {32'd0, run_param};

  always_comb begin
    step_nxt = step_r; busy_nxt = busy_r; item_nxt = item_r;
    phase_nxt = phase_r; acc_nxt = acc_r; zc_nxt = zc_r; rep_nxt = rep_r;
    colour_nxt = colour_r;
    num_done = 1'b0; num_val = '0;
    cmd_valid = 1'b0;
    cmd = '{kind: prld_pkg::CMD_NOP, value: 32'd0, black: 1'b0};
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt = 1'b1; item_nxt = in_data; step_nxt = 2'd0;
      end
    end else if (step_r == 2'd2) begin
      cmd_valid = 1'b1;
      cmd.kind = prld_pkg::CMD_END;
      if (cmd_ready) begin
        busy_nxt = 1'b0; phase_nxt = prld_pkg::PH_FIRST; acc_nxt = '0;
        zc_nxt = '0; rep_nxt = 1'b0; colour_nxt = 1'b0;
      end
    end else if (raw) begin
      cmd_valid = 1'b1;
      cmd.kind = prld_pkg::CMD_RAW;
      cmd.value = {24'd0, item_r.data_byte};
      if (cmd_ready) begin
        if (item_r.last_byte) step_nxt = 2'd2;
        else busy_nxt = 1'b0;
      end
    end else begin
      // Packed mode: a nybble moves on once its command, if any, is taken. Once
      // the glyph is complete the back end drops what follows, up to the end marker.
      unique case (phase_r)
        prld_pkg::PH_FIRST: begin
          if (d == 4'd0) begin
            zc_nxt = 4'd1; phase_nxt = prld_pkg::PH_ZEROS;
          end else if (d <= run_param) begin
            num_done = 1'b1; num_val = {28'd0, d};
          end else if (d <= 4'd13) begin
            acc_nxt = {28'd0, d}; phase_nxt = prld_pkg::PH_MEDIUM;
          end else if (!rep_r) begin
            if (d == 4'd14) rep_nxt = 1'b1;
            else begin
              cmd_valid = 1'b1; cmd.kind = prld_pkg::CMD_REPEAT; cmd.value = 32'd1;
            end
          end
        end
        prld_pkg::PH_MEDIUM: begin
          num_done = 1'b1; num_val = med_v;
        end
        prld_pkg::PH_ZEROS: begin
          if (d == 4'd0) begin
            if (zc_r != 4'd15) zc_nxt = zc_r + 4'd1;
          end else begin
            acc_nxt = {28'd0, d}; phase_nxt = prld_pkg::PH_DIGITS;
          end
        end
        default: begin
          acc_nxt = acc_shift;
          zc_nxt = (zc_r != 4'd0) ? zc_r - 4'd1 : 4'd0;
          if (zc_r <= 4'd1) begin
            num_done = 1'b1;
            num_val = (long_v > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : long_v[31:0];
          end
        end
      endcase
      if (num_done) begin
        phase_nxt = prld_pkg::PH_FIRST;
        cmd_valid = 1'b1;
        cmd.value = num_val;
        if (rep_r) begin
          cmd.kind = prld_pkg::CMD_REPEAT;
          rep_nxt = 1'b0;
        end else begin
          cmd.kind = prld_pkg::CMD_RUN;
          cmd.black = first_black ^ colour_r;
          colour_nxt = ~colour_r;
        end
      end
      if (cmd_valid && !cmd_ready) begin
        phase_nxt = phase_r; acc_nxt = acc_r; zc_nxt = zc_r;
        rep_nxt = rep_r; colour_nxt = colour_r;
      end else if (step_r == 2'd0) begin
        step_nxt = 2'd1;
      end else if (item_r.last_byte) begin
        step_nxt = 2'd2;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0; busy_r <= 1'b0; phase_r <= prld_pkg::PH_FIRST;
      acc_r <= '0; zc_r <= '0; rep_r <= 1'b0; colour_r <= 1'b0;
    end else begin
      step_r <= step_nxt; busy_r <= busy_nxt; phase_r <= phase_nxt;
      acc_r <= acc_nxt; zc_r <= zc_nxt; rep_r <= rep_nxt; colour_r <= colour_nxt;
    end
    item_r <= item_nxt;
  end

endmodule
`default_nettype wire

### src/prld_queue.sv
// ----------------------------------------------------------------------------
// prld_queue: two-entry command queue
// Decouples the parser from the row painter.
// ----------------------------------------------------------------------------
`default_nettype none
module prld_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire prld_pkg::cmd_t wr_data,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  output prld_pkg::cmd_t      rd_data,
  output logic                rd_valid,
  input  wire logic           rd_ready
);

  prld_pkg::cmd_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid & wr_ready;
  assign rd_en = rd_valid & rd_ready;

  always_comb begin
    wp_nxt = wr_en ? ~wp_r : wp_r;
    rp_nxt = rd_en ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule
`default_nettype wire

### src/prld_back.sv
// ----------------------------------------------------------------------------
// prld_back: row painter
// Paints runs and raw bits into the row buffer and emits finished rows.
// ----------------------------------------------------------------------------
`default_nettype none
module prld_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [6:0]          glyph_width,
  input  wire logic [6:0]          glyph_height,
  input  wire prld_pkg::cmd_t      cmd,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  output prld_pkg::out_item_t      out_data,
  output logic                     out_valid,
  input  wire logic                out_ready
);

  logic [31:0] run_r, run_nxt;
  logic        act_r, act_nxt;     // a command is being worked on
  logic        raw_r, raw_nxt;     // the command being worked on is raw bits
  logic        blk_r, blk_nxt;     // colour of the run being painted
  logic [63:0] buf_r, buf_nxt;
  logic [6:0]  col_r, col_nxt;
  logic [6:0]  rows_r, rows_nxt;
  logic [6:0]  rep_r, rep_nxt;
  logic [6:0]  pend_r, pend_nxt;   // repeat copies still to emit
  logic        emit_r, emit_nxt;   // a row is being emitted
  logic        zfill_r, zfill_nxt; // copies after the first are all zero
  logic [63:0] ebits_r, ebits_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  bit_r, bit_nxt;
  prld_pkg::out_item_t obuf_r, obuf_nxt;
  logic        ov_r, ov_nxt;

  logic [6:0]  w, h, space, n;
  logic [63:0] mask, fill;
  logic        oslot;

  assign w = (glyph_width == 7'd0) ? 7'd1 :
             (glyph_width > 7'(prld_pkg::MaxWidth)) ? 7'(prld_pkg::MaxWidth) : glyph_width;
  assign h = (glyph_height == 7'd0) ? 7'd1 :
             (glyph_height > 7'(prld_pkg::MaxHeight)) ? 7'(prld_pkg::MaxHeight) : glyph_height;
  assign mask = (w[6]) ? '1 : ~({64{1'b1}} >> w);
  assign space = (col_r >= w) ? 7'd0 : w - col_r;
  assign n = (run_r < {25'd0, space}) ? run_r[6:0] : space;
  assign fill = (n[6] ? '1 : ((64'd1 << n) - 64'd1)) << (7'd64 - col_r - n);
  assign oslot = !ov_r || out_ready;
  assign out_data = obuf_r;
  assign out_valid = ov_r;

  always_comb begin
    run_nxt = run_r; act_nxt = act_r; raw_nxt = raw_r; blk_nxt = blk_r;
    buf_nxt = buf_r; col_nxt = col_r;
    rows_nxt = rows_r; rep_nxt = rep_r; pend_nxt = pend_r; emit_nxt = emit_r;
    zfill_nxt = zfill_r;
    ebits_nxt = ebits_r; done_nxt = done_r; bit_nxt = bit_r;
    obuf_nxt = obuf_r; ov_nxt = ov_r && !out_ready;
    cmd_ready = 1'b0;
    if (emit_r) begin
      // Emit one row per cycle unless stalled: the first copy, then the repeats.
      if (oslot) begin
        ov_nxt = 1'b1;
        obuf_nxt = '{row_bits: ebits_r, row_index: rows_r[5:0],
                     last_row: (rows_r + 7'd1 >= h), error_flag: 1'b0};
        rows_nxt = rows_r + 7'd1;
        if (zfill_r) ebits_nxt = '0;
        if (pend_r != 7'd0 && rows_r + 7'd1 < h) pend_nxt = pend_r - 7'd1;
        else begin
          emit_nxt = 1'b0;
          zfill_nxt = 1'b0;
          if (rows_r + 7'd1 >= h) done_nxt = 1'b1;
        end
      end
    end else if (!act_r) begin
      if (cmd_valid) begin
        unique case (cmd.kind)
          prld_pkg::CMD_REPEAT: begin
            cmd_ready = 1'b1;
            rep_nxt = (cmd.value > 32'd127) ? 7'd127 : cmd.value[6:0];
          end
          prld_pkg::CMD_RUN, prld_pkg::CMD_RAW: begin
            cmd_ready = 1'b1;
            if (!done_r) begin
              act_nxt = 1'b1; run_nxt = cmd.value; bit_nxt = 3'd0;
              raw_nxt = (cmd.kind == prld_pkg::CMD_RAW); blk_nxt = cmd.black;
            end
          end
          prld_pkg::CMD_END: begin
            if (done_r) begin
              cmd_ready = 1'b1;
              run_nxt = '0; buf_nxt = '0; col_nxt = '0; rows_nxt = '0;
              rep_nxt = '0; done_nxt = 1'b0;
            end else if (cmd.value[0]) begin
              // Raw flush: the partial row, then zero rows until the glyph completes.
              emit_nxt = 1'b1; ebits_nxt = buf_r & mask; pend_nxt = 7'd127;
              zfill_nxt = 1'b1;
              buf_nxt = '0; col_nxt = '0; rep_nxt = '0;
            end else if (oslot) begin
              cmd_ready = 1'b1;
              ov_nxt = 1'b1;
              obuf_nxt = '{row_bits: 64'd0, row_index: rows_r[5:0],
                           last_row: 1'b1, error_flag: 1'b1};
              run_nxt = '0; buf_nxt = '0; col_nxt = '0; rows_nxt = '0;
              rep_nxt = '0;
            end
          end
          default: cmd_ready = 1'b1;
        endcase
      end
    end else if (raw_r) begin
      // One raw bit per cycle while no row is being emitted.
      if (done_r) begin
        act_nxt = 1'b0;
      end else if (col_r >= w) begin
        emit_nxt = 1'b1; ebits_nxt = buf_r & mask; pend_nxt = 7'd0;
        buf_nxt = '0; col_nxt = '0; rep_nxt = '0;
      end else begin
        if (run_r[{2'd0, 3'd7 - bit_r}]) buf_nxt = buf_r | (64'd1 << (7'd63 - col_r));
        col_nxt = col_r + 7'd1;
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) act_nxt = 1'b0;
        if (col_r + 7'd1 >= w) begin
          emit_nxt = 1'b1; ebits_nxt = buf_nxt & mask; pend_nxt = 7'd0;
          buf_nxt = '0; col_nxt = '0; rep_nxt = '0;
        end
      end
    end else begin
      // Run painting: one row segment per cycle while no row is being emitted.
      if (run_r == 32'd0 || done_r) begin
        act_nxt = 1'b0;
      end else if (col_r >= w) begin
        emit_nxt = 1'b1; ebits_nxt = buf_r & mask; pend_nxt = rep_r;
        buf_nxt = '0; col_nxt = '0; rep_nxt = '0;
      end else begin
        if (blk_r) buf_nxt = buf_r | fill;
        col_nxt = col_r + n;
        run_nxt = run_r - {25'd0, n};
        if (col_r + n >= w) begin
          emit_nxt = 1'b1; ebits_nxt = buf_nxt & mask; pend_nxt = rep_r;
          buf_nxt = '0; col_nxt = '0; rep_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0; act_r <= 1'b0; buf_r <= '0; col_r <= '0; rows_r <= '0;
      rep_r <= '0; pend_r <= '0; emit_r <= 1'b0; done_r <= 1'b0; bit_r <= '0;
      ov_r <= 1'b0; raw_r <= 1'b0; blk_r <= 1'b0; zfill_r <= 1'b0;
    end else begin
      run_r <= run_nxt; act_r <= act_nxt; buf_r <= buf_nxt; col_r <= col_nxt;
      rows_r <= rows_nxt; rep_r <= rep_nxt; pend_r <= pend_nxt;
      emit_r <= emit_nxt; done_r <= done_nxt; bit_r <= bit_nxt; ov_r <= ov_nxt;
      raw_r <= raw_nxt; blk_r <= blk_nxt; zfill_r <= zfill_nxt;
    end
    ebits_r <= ebits_nxt;
    obuf_r <= obuf_nxt;
  end

endmodule
`default_nettype wire

### src/packed_run_length_raster_decoder_core.sv
// ----------------------------------------------------------------------------
// packed_run_length_raster_decoder_core: glyph raster decoder
// Turns the packed or raw raster bytes of one glyph into bitmap rows.
// ----------------------------------------------------------------------------
// Each input item is one raster byte. The front parser first takes the byte
// and then works through its two nybbles in packed mode or passes it on whole
// in raw mode, and a byte flagged as last adds an end marker. The row painter
// behind a two-entry command queue takes each command, paints a run row
// segment by row segment and then retires it, paints raw bits one at a time
// and emits each finished row, so long runs and repeated rows hold the input
// back. Rows leave with the leftmost pixel in bit 63. A byte flagged as last
// ends the glyph: in packed mode an unfinished glyph yields one error item,
// in raw mode the partial row is emitted and the remaining rows zero-filled.
// Configuration must be written through the APB-style port at byte addresses
// 0, 4, 8 and 12 while the block is idle; the block itself does not enforce it.
`default_nettype none
module packed_run_length_raster_decoder_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire prld_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output prld_pkg::out_item_t      out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [3:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);

  logic [3:0] run_param_r;
  logic       first_black_r;
  logic [6:0] width_r, height_r;
  logic [1:0] reg_sel;

  prld_pkg::cmd_t f_cmd, q_cmd, b_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  assign cfg_pready = 1'b1;
  assign reg_sel = cfg_paddr[3:2];

  always_comb begin
    unique case (reg_sel)
      prld_pkg::REG_RUN_PARAM:   cfg_prdata = {28'd0, run_param_r};
      prld_pkg::REG_FIRST_BLACK: cfg_prdata = {31'd0, first_black_r};
      prld_pkg::REG_GLYPH_WIDTH: cfg_prdata = {25'd0, width_r};
      default:                   cfg_prdata = {25'd0, height_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_param_r <= 4'd0; first_black_r <= 1'b0; width_r <= 7'd1; height_r <= 7'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_sel)
        prld_pkg::REG_RUN_PARAM:   run_param_r <= cfg_pwdata[3:0];
        prld_pkg::REG_FIRST_BLACK: first_black_r <= cfg_pwdata[0];
        prld_pkg::REG_GLYPH_WIDTH: width_r <= cfg_pwdata[6:0];
        default:                   height_r <= cfg_pwdata[6:0];
      endcase
    end
  end

  prld_front u_front (
    .clk, .rst_n, .run_param(run_param_r), .first_black(first_black_r),
    .in_data, .in_valid, .in_ready,
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  // End commands carry the raw-mode flag in bit 0 of their value.
  always_comb begin
    b_cmd = f_cmd;
    if (f_cmd.kind == prld_pkg::CMD_END)
      b_cmd.value = {31'd0, run_param_r[3] & run_param_r[2] & run_param_r[1]};
  end

  prld_queue u_queue (
    .clk, .rst_n, .wr_data(b_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  prld_back u_back (
    .clk, .rst_n, .glyph_width(width_r), .glyph_height(height_r),
    .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .out_data, .out_valid, .out_ready
  );

endmodule
`default_nettype wire

### verif/tb_packed_run_length_raster_decoder_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_run_length_raster_decoder_core: self-checking bench of the decoder
// Writes the configuration over the register port, feeds glyph raster bytes in
// packed and raw mode, predicts every bitmap row with a behavioural decoder of
// its own and compares each result item, field by field, as it leaves.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_packed_run_length_raster_decoder_core;

  localparam int WatchdogLimit = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  prld_pkg::in_item_t in_data;
  prld_pkg::out_item_t out_data;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  packed_run_length_raster_decoder_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Shadow registers and decoder state.
  logic [3:0] sh_param;
  logic sh_black;
  logic [6:0] sh_width, sh_height;
  logic [31:0] run_left, accum;
  logic colour, repeat_parse, glyph_done;
  logic [63:0] row_buf;
  int unsigned col, rows_done, row_rep, zeros;
  prld_pkg::phase_t phase;

  prld_pkg::out_item_t expected_rows[$];
  prld_pkg::in_item_t pending_bytes[$];
  int unsigned accepted_bytes;
  bit failed;
  bit long_hold_req;

  function automatic int unsigned width_eff();
    return (sh_width < 1) ? 1 : (sh_width > 64 ? 64 : sh_width);
  endfunction

  function automatic int unsigned height_eff();
    return (sh_height < 1) ? 1 : (sh_height > 64 ? 64 : sh_height);
  endfunction

  function automatic void clear_glyph();
    run_left = 0; colour = 0; row_buf = '0; col = 0; rows_done = 0; row_rep = 0;
    phase = prld_pkg::PH_FIRST; accum = 0; zeros = 0; repeat_parse = 0; glyph_done = 0;
  endfunction

  function automatic void push_row(logic [63:0] bits, int unsigned idx, bit last,
                                   bit err);
    prld_pkg::out_item_t r;
    r.row_bits = bits; r.row_index = idx[5:0]; r.last_row = last; r.error_flag = err;
    expected_rows.push_back(r);
  endfunction

  function automatic void close_row(int unsigned rep);
    int unsigned h, w;
    logic [63:0] bits;
    h = height_eff(); w = width_eff();
    bits = row_buf & ~({64{1'b1}} >> w);
    if (w >= 64) bits = row_buf;
    if (rows_done < h) begin
      push_row(bits, rows_done, rows_done + 1 >= h, 0);
      rows_done++;
      while (rep > 0 && rows_done < h) begin
        push_row(bits, rows_done, rows_done + 1 >= h, 0);
        rows_done++; rep--;
      end
    end
    if (rows_done >= h) glyph_done = 1;
    row_buf = '0; col = 0; row_rep = 0;
  endfunction

  function automatic void paint_run(bit black);
    int unsigned w, n;
    logic [63:0] m;
    while (run_left > 0 && !glyph_done) begin
      w = width_eff();
      if (col >= w) begin
        close_row(row_rep);
        continue;
      end
      n = (run_left < w - col) ? run_left : w - col;
      if (black) begin
        m = (n >= 64) ? '1 : ((64'd1 << n) - 1);
        m = m << (64 - col - n);
        row_buf |= m;
      end
      col += n; run_left -= n;
      if (col >= w) close_row(row_rep);
    end
  endfunction

  function automatic void number_parsed(logic [31:0] value);
    bit black;
    phase = prld_pkg::PH_FIRST;
    if (repeat_parse) begin
      row_rep = (value > 127) ? 127 : value;
      repeat_parse = 0;
      return;
    end
    black = sh_black ^ colour;
    colour = ~colour;
    run_left = value;
    paint_run(black);
  endfunction

  function automatic void take_nybble(logic [3:0] d);
    logic [63:0] v;
    if (glyph_done) return;
    case (phase)
      prld_pkg::PH_FIRST: begin
        if (d == 0) begin
          zeros = 1; phase = prld_pkg::PH_ZEROS;
        end else if (d <= sh_param) begin
          number_parsed(32'(d));
        end else if (d <= 13) begin
          accum = d; phase = prld_pkg::PH_MEDIUM;
        end else if (!repeat_parse) begin
          if (d == 14) repeat_parse = 1;
          else row_rep = 1;
        end
      end
      prld_pkg::PH_MEDIUM: number_parsed((accum - sh_param - 1) * 16 + d + sh_param + 1);
      prld_pkg::PH_ZEROS: begin
        if (d == 0) begin
          if (zeros < 15) zeros++;
        end else begin
          accum = d; phase = prld_pkg::PH_DIGITS;
        end
      end
      default: begin
        accum = (accum > 32'h0FFF_FFFF) ? 32'hFFFF_FFFF : accum * 16 + d;
        if (zeros > 0) zeros--;
        if (zeros == 0) begin
          v = 64'(accum) - 15 + 64'(13 - sh_param) * 16 + sh_param;
          if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
          number_parsed(v[31:0]);
        end
      end
    endcase
  endfunction

  function automatic void decode_byte(prld_pkg::in_item_t it);
    bit raw;
    int unsigned w;
    raw = sh_param >= 14;
    if (raw) begin
      for (int i = 7; i >= 0 && !glyph_done; i--) begin
        w = width_eff();
        if (col >= w) begin
          close_row(0);
          if (glyph_done) break;
        end
        if (it.data_byte[i]) row_buf[63 - col] = 1'b1;
        col++;
        if (col >= w) close_row(0);
      end
    end else begin
      take_nybble(it.data_byte[7:4]);
      take_nybble(it.data_byte[3:0]);
    end
    if (it.last_byte) begin
      if (!glyph_done) begin
        if (raw) begin
          while (!glyph_done) close_row(0);
        end else begin
          push_row('0, rows_done, 1, 1);
        end
      end
      clear_glyph();
    end
  endfunction

  // Driver: offers queued items, mostly back to back, sometimes after a short gap, now and then after a long one.
  int unsigned gap_count;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_count <= 0;
    end else if (in_valid && !in_ready) begin
      // hold the item until it is taken
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(in_data);
        accepted_bytes++;
      end
      if (gap_count > 0) begin
        gap_count <= gap_count - 1;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_data <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 24) == 0) gap_count <= $urandom_range(12, 60);
        else if ($urandom_range(0, 3) == 0) gap_count <= $urandom_range(1, 3);
        else gap_count <= 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, long hold when asked.
  int unsigned hold_count;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: unexpected row %h", $time, out_data);
          failed = 1;
        end else begin
          prld_pkg::out_item_t e;
          e = expected_rows.pop_front();
          if (e.row_bits !== out_data.row_bits)
            $display("%0t: row_bits exp %h got %h", $time, e.row_bits, out_data.row_bits);
          if (e.row_index !== out_data.row_index)
            $display("%0t: row_index exp %0d got %0d", $time, e.row_index,
                     out_data.row_index);
          if (e.last_row !== out_data.last_row)
            $display("%0t: last_row exp %b got %b", $time, e.last_row, out_data.last_row);
          if (e.error_flag !== out_data.error_flag)
            $display("%0t: error_flag exp %b got %b", $time, e.error_flag,
                     out_data.error_flag);
          if (e !== out_data) failed = 1;
        end
      end
      if (hold_count > 0) begin
        hold_count <= hold_count - 1;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req <= 1'b0;
        hold_count <= 300;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 30) == 0) begin
        hold_count <= $urandom_range(1, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 4) != 0);
      end
    end
  end

  // Watchdog on progress.
  int unsigned idle_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n ||
        hold_count > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      prld_pkg::REG_RUN_PARAM:    sh_param  = value[3:0];
      prld_pkg::REG_FIRST_BLACK:  sh_black  = value[0];
      prld_pkg::REG_GLYPH_WIDTH:  sh_width  = value[6:0];
      default:                    sh_height = value[6:0];
    endcase
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic configure(int unsigned p, bit b, int unsigned w, int unsigned h);
    drain();
    write_reg(prld_pkg::REG_RUN_PARAM, p);
    write_reg(prld_pkg::REG_FIRST_BLACK, b);
    write_reg(prld_pkg::REG_GLYPH_WIDTH, w);
    write_reg(prld_pkg::REG_GLYPH_HEIGHT, h);
  endtask

  task automatic add_byte(logic [7:0] b, bit last);
    prld_pkg::in_item_t it;
    it.data_byte = b; it.last_byte = last;
    pending_bytes.push_back(it);
  endtask

  // A random glyph of random bytes with repeat prefixes and long numbers mixed in, sometimes left unfinished.
  task automatic random_glyph(int unsigned n);
    for (int i = 0; i < n; i++) begin
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0) add_byte({4'd14, 4'($urandom_range(1, 13))}, 0);
      else if (k == 1) add_byte({4'd15, 4'($urandom)}, 0);
      else if (k == 2) add_byte({4'd0, 4'($urandom_range(1, 15))}, 0);
      else add_byte(8'($urandom), 0);
    end
    add_byte(8'($urandom), 1);
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_data = '0; out_ready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    failed = 0; accepted_bytes = 0; long_hold_req = 0;
    sh_param = 0; sh_black = 0; sh_width = 1; sh_height = 1;
    clear_glyph();
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // Directed: packed forms, repeat prefixes and data running out.
    configure(7, 1, 8, 4);
    add_byte(8'h35, 0); add_byte(8'hE2, 0); add_byte(8'h44, 0);
    add_byte(8'hF8, 0); add_byte(8'h08, 0); add_byte(8'hFF, 0); add_byte(8'h00, 1);
    add_byte(8'h12, 1);
    configure(0, 0, 64, 64);
    add_byte(8'h00, 0); add_byte(8'h00, 0); add_byte(8'h01, 0); add_byte(8'hFF, 1);
    add_byte(8'hDD, 0); add_byte(8'hE1, 0); add_byte(8'h3F, 1);
    configure(13, 1, 1, 1);
    add_byte(8'h1E, 0); add_byte(8'hEE, 0); add_byte(8'hFF, 1);
    // Raw mode, short data and bytes past the end.
    configure(14, 0, 5, 3);
    add_byte(8'hA5, 0); add_byte(8'h0F, 0); add_byte(8'hFF, 0); add_byte(8'h81, 1);
    add_byte(8'hC3, 1);
    configure(15, 1, 64, 8);
    add_byte(8'hFF, 0); add_byte(8'h55, 1);

    // Long receiver stall while the sender keeps offering.
    configure(2, 0, 16, 64);
    long_hold_req = 1;
    random_glyph(20);

    // Random phases.
    for (int g = 0; g < 40; g++) begin
      int unsigned p;
      if (g % 5 == 0) begin
        p = $urandom_range(0, 4) == 0 ? $urandom_range(14, 15) : $urandom_range(0, 13);
        configure(p, $urandom_range(0, 1),
                  $urandom_range(0, 3) == 0 ? 64 : $urandom_range(1, 20),
                  $urandom_range(0, 3) == 0 ? 64 : $urandom_range(1, 12));
      end
      random_glyph($urandom_range(2, 14));
    end

    drain();
    if (!failed && expected_rows.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
src/prld_pkg.sv
src/prld_front.sv
src/prld_queue.sv
src/prld_back.sv
src/packed_run_length_raster_decoder_core.sv
verif/tb_packed_run_length_raster_decoder_core.sv
